### rtl/test_tone_marker_generator_macros.svh
// ----------------------------------------------------------------------------
// Test tone marker generator: assertion macros
// Concurrent check wrappers; empty when synthesising.
// ----------------------------------------------------------------------------
`ifndef TEST_TONE_MARKER_GENERATOR_MACROS_SVH
`define TEST_TONE_MARKER_GENERATOR_MACROS_SVH

`ifndef SYNTHESIS
`define TTMG_ASSERT_SAME(label, clk, rst, a, c) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
      else $error("same-cycle check failed");
`define TTMG_ASSERT_NEXT(label, clk, rst, a, c) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
      else $error("next-cycle check failed");
`else
`define TTMG_ASSERT_SAME(label, clk, rst, a, c)
`define TTMG_ASSERT_NEXT(label, clk, rst, a, c)
`endif

`endif

### rtl/ttmg_pkg.sv
// ----------------------------------------------------------------------------
// ttmg_pkg
// Shared widths, register codes and sine table builder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
package ttmg_pkg;

   localparam int FRAME_W    = 48;
   localparam int RATE_W     = 18;
   localparam int TONE_W     = 27;
   localparam int AMP_W      = 17;
   localparam int CSR_DATA_W = 27;
   // 2000 * rate and 3 * tone both fit here
   localparam int DEN_W      = 29;
   localparam int BURST_HZ   = 1000;

   localparam logic [RATE_W-1:0] RATE_RESET = 18'd48000;
   localparam logic [TONE_W-1:0] TONE_RESET = 27'd440000;
   localparam logic [AMP_W-1:0]  AMP_RESET  = 17'd16384;

   localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
   localparam logic [63:0] ONE_Q30     = 64'd1073741824;

   typedef enum logic [1:0] {
      CSR_SAMPLE_RATE = 2'd0,
      CSR_TONE        = 2'd1,
      CSR_AMPLITUDE   = 2'd2,
      CSR_MARKER_MODE = 2'd3
   } csr_index_type;

   typedef logic signed [31:0] sine_type;

   // Quarter-wave entry k in Q1.30, Taylor series to seven terms
   function automatic logic [30:0] sine_entry(input int unsigned k, input int unsigned qbits);
      logic [63:0] x;
      logic [63:0] x2;
      logic [63:0] term;
      logic signed [63:0] sum;
      x    = (HALF_PI_Q30 * 64'(k)) >> qbits;
      x2   = (x * x) >> 30;
      sum  = signed'(x);
      term = ((x * x2) >> 30) / 64'd6;
      sum  = sum - signed'(term);
      term = ((term * x2) >> 30) / 64'd20;
      sum  = sum + signed'(term);
      term = ((term * x2) >> 30) / 64'd42;
      sum  = sum - signed'(term);
      term = ((term * x2) >> 30) / 64'd72;
      sum  = sum + signed'(term);
      term = ((term * x2) >> 30) / 64'd110;
      sum  = sum - signed'(term);
      term = ((term * x2) >> 30) / 64'd156;
      sum  = sum + signed'(term);
      term = ((term * x2) >> 30) / 64'd210;
      sum  = sum - signed'(term);
      if (sum < 0) sum = 0;
      if (sum > signed'(ONE_Q30)) sum = signed'(ONE_Q30);
      return sum[30:0];
   endfunction

endpackage

### rtl/ttmg_mod_pipe.sv
// ----------------------------------------------------------------------------
// ttmg_mod_pipe
// Pipelined restoring remainder: one numerator bit per stage.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module ttmg_mod_pipe #(
   parameter int NW = 48,
   parameter int DW = 29
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          in_valid,
   input  logic [NW-1:0] in_num,
   input  logic [DW-1:0] den,
   output logic          out_valid,
   output logic [DW-1:0] out_rem
);

   logic [NW-1:0] num_ff [NW];
   logic [DW-1:0] rem_ff [NW];
   logic          vld_ff [NW];

   for (genvar s = 0; s < NW; s++) begin : g_stage
      logic [NW-1:0] src_num;
      logic [DW-1:0] src_rem;
      logic          src_vld;
      logic [DW:0]   trial;
      logic [DW:0]   rem_in;

      if (s == 0) begin : g_first
         assign src_num = in_num;
         assign src_rem = '0;
         assign src_vld = in_valid;
      end else begin : g_next
         assign src_num = num_ff[s-1];
         assign src_rem = rem_ff[s-1];
         assign src_vld = vld_ff[s-1];
      end

      // shift in the next bit and subtract the divisor where it fits
      always_comb begin
         trial  = {src_rem, src_num[NW-1]};
         rem_in = (trial >= {1'b0, den}) ? (trial - {1'b0, den}) : trial;
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[s] <= 1'b0;
         end else begin
            vld_ff[s] <= src_vld;
         end
         num_ff[s] <= src_num << 1;
         rem_ff[s] <= rem_in[DW-1:0];
      end
   end

   assign out_valid = vld_ff[NW-1];
   assign out_rem   = rem_ff[NW-1];

endmodule

### rtl/ttmg_frac_pipe.sv
// ----------------------------------------------------------------------------
// ttmg_frac_pipe
// Pipelined fraction: floor(rem * 2^QW / den) for rem below den.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module ttmg_frac_pipe #(
   parameter int QW = 10,
   parameter int DW = 29
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          in_valid,
   input  logic [DW-1:0] in_rem,
   input  logic [DW-1:0] den,
   output logic          out_valid,
   output logic [QW-1:0] out_quo
);

   logic [DW-1:0] rem_ff [QW];
   logic [QW-1:0] quo_ff [QW];
   logic          vld_ff [QW];

   for (genvar s = 0; s < QW; s++) begin : g_stage
      logic [DW-1:0] src_rem;
      logic [QW-1:0] src_quo;
      logic          src_vld;
      logic [DW:0]   trial;
      logic          fits;

      if (s == 0) begin : g_first
         assign src_rem = in_rem;
         assign src_quo = '0;
         assign src_vld = in_valid;
      end else begin : g_next
         assign src_rem = rem_ff[s-1];
         assign src_quo = quo_ff[s-1];
         assign src_vld = vld_ff[s-1];
      end

      // double the remainder and take one quotient bit
      always_comb begin
         trial = {src_rem, 1'b0};
         fits  = trial >= {1'b0, den};
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[s] <= 1'b0;
         end else begin
            vld_ff[s] <= src_vld;
         end
         rem_ff[s] <= fits ? DW'(trial - {1'b0, den}) : DW'(trial);
         quo_ff[s] <= (src_quo << 1) | QW'(fits);
      end
   end

   assign out_valid = vld_ff[QW-1];
   assign out_quo   = quo_ff[QW-1];

endmodule

### rtl/ttmg_delay.sv
// ----------------------------------------------------------------------------
// ttmg_delay
// Fixed-length shift line to align side paths with the tone path.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module ttmg_delay #(
   parameter int W = 1,
   parameter int L = 1
) (
   input  logic         clock,
   input  logic         reset,
   input  logic [W-1:0] in_data,
   output logic [W-1:0] out_data
);

   logic [W-1:0] tap_ff [L];

   // advance every tap; clear on reset so carried valid bits drop
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < L; i++) tap_ff[i] <= '0;
      end else begin
         tap_ff[0] <= in_data;
         for (int i = 1; i < L; i++) tap_ff[i] <= tap_ff[i-1];
      end
   end

   assign out_data = tap_ff[L-1];

endmodule

### rtl/test_tone_marker_generator.sv
// ----------------------------------------------------------------------------
// test_tone_marker_generator
// DDS test tone with optional 1 kHz marker bursts, repeated once per second.
//
//   channel   direction  transfer at edge where
//   req_*     in         start && !busy (busy is held low)
//   rsp_*     out        rsp_valid (one cycle, no back pressure)
//   csr_*     in         csr_valid && csr_ready (ready held high)
//
// One item enters every cycle. Items pass through the bit-per-stage remainder
// chains (frame mod 2000*rate, then the 58-bit phase product mod 2000*rate),
// then the phase fraction stages and the output stages.
// Synchronous reset clears valid bits and loads the register defaults.
// Register writes reach the derived divisors in the following cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "test_tone_marker_generator_macros.svh"
module test_tone_marker_generator #(
   parameter int SINE_TABLE_BITS = 10,
   parameter int SAMPLE_WIDTH    = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   output logic                                 busy,
   input  logic [ttmg_pkg::FRAME_W-1:0]         req_frame_index,
   input  logic                                 req_channel_number,
   output logic                                 rsp_valid,
   output logic signed [SAMPLE_WIDTH-1:0]       rsp_sample_value,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  ttmg_pkg::csr_index_type              csr_index,
   input  logic [ttmg_pkg::CSR_DATA_W-1:0]      csr_wdata
);

   localparam int RW     = ttmg_pkg::RATE_W;
   localparam int DW     = ttmg_pkg::DEN_W;
   localparam int TB     = SINE_TABLE_BITS;
   localparam int QBITS  = TB - 2;
   localparam int QLEN   = 1 << QBITS;
   localparam int TPW    = 2 * DW;       // tone phase product width
   localparam int BPW    = RW + 10;      // burst phase product width
   localparam int ENV_QW = 16;
   localparam int SH     = 47 - SAMPLE_WIDTH;
   localparam int BURST_PAD = TPW - BPW;
   localparam int ENV_PAD   = TPW + TB - ENV_QW;
   localparam logic signed [52:0] RND = 53'sd1 <<< (SH - 1);
   localparam logic signed [52:0] HI  = (53'sd1 <<< (SAMPLE_WIDTH - 1)) - 53'sd1;
   localparam logic signed [52:0] LO  = -(53'sd1 <<< (SAMPLE_WIDTH - 1));

   // configuration registers
   logic [RW-1:0]                 sr_ff;
   logic [ttmg_pkg::TONE_W-1:0]   tone_ff;
   logic [ttmg_pkg::AMP_W-1:0]    amp_ff;
   logic                          marker_ff;

   // derived divisors and multipliers
   logic [RW-1:0] sr1_ff;
   logic [DW-1:0] den_ff;
   logic [DW-1:0] num2_ff;
   logic [DW-1:0] num3_ff;
   logic [RW:0]   sr2_ff;
   logic [21:0]   sr15_ff;
   logic [22:0]   sr16_ff;

   logic accept;

   assign busy      = 1'b0;
   assign csr_ready = 1'b1;
   assign accept    = start & ~busy;

   // take register writes; unknown codes cannot arise on a two-bit index
   always_ff @(posedge clock) begin
      if (reset) begin
         sr_ff     <= ttmg_pkg::RATE_RESET;
         tone_ff   <= ttmg_pkg::TONE_RESET;
         amp_ff    <= ttmg_pkg::AMP_RESET;
         marker_ff <= 1'b1;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            ttmg_pkg::CSR_SAMPLE_RATE: sr_ff     <= csr_wdata[RW-1:0];
            ttmg_pkg::CSR_TONE:        tone_ff   <= csr_wdata;
            ttmg_pkg::CSR_AMPLITUDE:   amp_ff    <= csr_wdata[ttmg_pkg::AMP_W-1:0];
            ttmg_pkg::CSR_MARKER_MODE: marker_ff <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // hold the derived constants, treating a zero rate as one
   logic [RW-1:0] sr1_in;
   assign sr1_in = (sr_ff == '0) ? RW'(1) : sr_ff;

   always_ff @(posedge clock) begin
      sr1_ff  <= sr1_in;
      den_ff  <= DW'(sr1_in) * DW'(2000);
      num2_ff <= DW'(tone_ff) * DW'(2);
      num3_ff <= DW'(tone_ff) * DW'(3);
      sr2_ff  <= (RW + 1)'(sr1_in) << 1;
      sr15_ff <= 22'(sr1_in) * 22'd15;
      sr16_ff <= 23'(sr1_in) << 4;
   end

   // frame reduced modulo both divisors
   logic          a_valid;
   logic          a_valid_r;
   logic [DW-1:0] a_fm;
   logic [RW-1:0] a_p;
   logic          a_chan;

   ttmg_mod_pipe #(.NW(ttmg_pkg::FRAME_W), .DW(DW)) u_frame_mod_tone (
      .clock(clock), .reset(reset), .in_valid(accept), .in_num(req_frame_index),
      .den(den_ff), .out_valid(a_valid), .out_rem(a_fm)
   );

   ttmg_mod_pipe #(.NW(ttmg_pkg::FRAME_W), .DW(RW)) u_frame_mod_rate (
      .clock(clock), .reset(reset), .in_valid(accept), .in_num(req_frame_index),
      .den(sr1_ff), .out_valid(a_valid_r), .out_rem(a_p)
   );

   ttmg_delay #(.W(1), .L(ttmg_pkg::FRAME_W)) u_chan_delay (
      .clock(clock), .reset(reset), .in_data(req_channel_number), .out_data(a_chan)
   );

   // form phase products and the envelope numerator
   logic           m_valid_ff;
   logic [TPW-1:0] m_prod_ff;
   logic [BPW-1:0] m_pb_ff;
   logic [RW-1:0]  m_a_ff;
   logic [1:0]     m_flag_ff;
   logic [25:0]    c200;
   logic           in_win;
   logic           ramp_up;
   logic           ramp_dn;
   logic [RW-1:0]  a_in;

   always_comb begin
      c200    = 26'(a_p) * 26'd200;
      in_win  = (23'(a_p) * 23'd25) < 23'(sr2_ff);
      ramp_up = c200 < 26'(sr1_ff);
      ramp_dn = c200 > 26'(sr15_ff);
      if (in_win && ramp_up) begin
         a_in = c200[RW-1:0];
      end else if (in_win && ramp_dn) begin
         a_in = RW'(26'(sr16_ff) - c200);
      end else begin
         a_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         m_valid_ff <= 1'b0;
      end else begin
         m_valid_ff <= a_valid;
      end
      m_prod_ff <= TPW'(a_fm) * TPW'(a_chan ? num3_ff : num2_ff);
      m_pb_ff   <= BPW'(a_p) * BPW'(ttmg_pkg::BURST_HZ);
      m_a_ff    <= a_in;
      m_flag_ff <= {in_win, ramp_up | ramp_dn};
   end

   // tone phase index
   logic          t_mvalid;
   logic [DW-1:0] t_rem;
   logic          t_valid;
   logic [TB-1:0] t_idx;

   ttmg_mod_pipe #(.NW(TPW), .DW(DW)) u_tone_mod (
      .clock(clock), .reset(reset), .in_valid(m_valid_ff), .in_num(m_prod_ff),
      .den(den_ff), .out_valid(t_mvalid), .out_rem(t_rem)
   );

   ttmg_frac_pipe #(.QW(TB), .DW(DW)) u_tone_frac (
      .clock(clock), .reset(reset), .in_valid(t_mvalid), .in_rem(t_rem),
      .den(den_ff), .out_valid(t_valid), .out_quo(t_idx)
   );

   // burst phase index, padded to the tone latency
   logic          b_mvalid;
   logic [RW-1:0] b_rem;
   logic          b_fvalid;
   logic [TB-1:0] b_fidx;
   logic          b_valid;
   logic [TB-1:0] b_idx;

   ttmg_mod_pipe #(.NW(BPW), .DW(RW)) u_burst_mod (
      .clock(clock), .reset(reset), .in_valid(m_valid_ff), .in_num(m_pb_ff),
      .den(sr1_ff), .out_valid(b_mvalid), .out_rem(b_rem)
   );

   ttmg_frac_pipe #(.QW(TB), .DW(RW)) u_burst_frac (
      .clock(clock), .reset(reset), .in_valid(b_mvalid), .in_rem(b_rem),
      .den(sr1_ff), .out_valid(b_fvalid), .out_quo(b_fidx)
   );

   ttmg_delay #(.W(TB + 1), .L(BURST_PAD)) u_burst_delay (
      .clock(clock), .reset(reset), .in_data({b_fvalid, b_fidx}),
      .out_data({b_valid, b_idx})
   );

   // envelope: ramp fraction, flat top or silence
   logic              e_fvalid;
   logic [ENV_QW-1:0] e_q;
   logic [1:0]        e_flag;
   logic [16:0]       env_w;
   logic              e_valid;
   logic [16:0]       env_al;

   ttmg_frac_pipe #(.QW(ENV_QW), .DW(RW)) u_env_frac (
      .clock(clock), .reset(reset), .in_valid(m_valid_ff), .in_rem(m_a_ff),
      .den(sr1_ff), .out_valid(e_fvalid), .out_quo(e_q)
   );

   ttmg_delay #(.W(2), .L(ENV_QW)) u_env_flag_delay (
      .clock(clock), .reset(reset), .in_data(m_flag_ff), .out_data(e_flag)
   );

   always_comb begin
      if (!e_flag[1]) begin
         env_w = '0;
      end else if (e_flag[0]) begin
         env_w = {1'b0, e_q};
      end else begin
         env_w = 17'd65536;
      end
   end

   ttmg_delay #(.W(18), .L(ENV_PAD)) u_env_delay (
      .clock(clock), .reset(reset), .in_data({e_fvalid, env_w}),
      .out_data({e_valid, env_al})
   );

   // quarter-wave table, built at elaboration
   logic [30:0] sine_rom [QLEN + 1];

   for (genvar gk = 0; gk <= QLEN; gk++) begin : g_rom
      assign sine_rom[gk] = ttmg_pkg::sine_entry(gk, QBITS);
   end

   // fold both phase indices onto the table
   logic [TB-1:0]      lane_idx [2];
   ttmg_pkg::sine_type lane_val [2];

   assign lane_idx[0] = t_idx;
   assign lane_idx[1] = b_idx;

   for (genvar gl = 0; gl < 2; gl++) begin : g_lane
      logic [QBITS:0] addr;
      logic [30:0]    mag;
      always_comb begin
         if (lane_idx[gl][TB-2]) begin
            addr = (QBITS + 1)'(QLEN) - (QBITS + 1)'(lane_idx[gl][QBITS-1:0]);
         end else begin
            addr = (QBITS + 1)'(lane_idx[gl][QBITS-1:0]);
         end
         mag = sine_rom[addr];
         lane_val[gl] = lane_idx[gl][TB-1] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
      end
   end

   // mix, gain, round and saturate over six stages
   logic               f1_valid_ff;
   ttmg_pkg::sine_type f1_tone_ff;
   ttmg_pkg::sine_type f1_burst_ff;
   logic [16:0]        f1_env_ff;
   logic               f2_valid_ff;
   logic signed [49:0] f2_eb_ff;
   logic signed [47:0] f2_tw_ff;
   ttmg_pkg::sine_type f2_tone_ff;
   logic               f3_valid_ff;
   logic signed [49:0] f3_bw_ff;
   logic signed [47:0] f3_tw_ff;
   ttmg_pkg::sine_type f3_tone_ff;
   logic               f4_valid_ff;
   logic signed [34:0] f4_v_ff;
   logic               f5_valid_ff;
   logic signed [52:0] f5_prod_ff;
   logic               rsp_valid_ff;
   logic signed [SAMPLE_WIDTH-1:0] rsp_sample_ff;

   logic signed [33:0] eb_sh;
   logic signed [50:0] mix_sum;
   logic signed [34:0] mix_in;
   logic signed [17:0] amp_s;
   logic signed [52:0] rnd_sum;
   logic signed [52:0] res_in;

   always_comb begin
      eb_sh   = 34'(f2_eb_ff >>> 16);
      mix_sum = 51'(f3_tw_ff) + 51'(f3_bw_ff);
      mix_in  = 35'(mix_sum >>> 16);
      amp_s   = $signed({1'b0, amp_ff});
      rnd_sum = f5_prod_ff + RND;
      res_in  = rnd_sum >>> SH;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         f1_valid_ff  <= 1'b0;
         f2_valid_ff  <= 1'b0;
         f3_valid_ff  <= 1'b0;
         f4_valid_ff  <= 1'b0;
         f5_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         f1_valid_ff  <= t_valid;
         f2_valid_ff  <= f1_valid_ff;
         f3_valid_ff  <= f2_valid_ff;
         f4_valid_ff  <= f3_valid_ff;
         f5_valid_ff  <= f4_valid_ff;
         rsp_valid_ff <= f5_valid_ff;
      end
      f1_tone_ff  <= lane_val[0];
      f1_burst_ff <= lane_val[1];
      f1_env_ff   <= env_al;
      f2_eb_ff    <= 50'($signed({1'b0, f1_env_ff})) * 50'(f1_burst_ff);
      f2_tw_ff    <= 48'(f1_tone_ff) * 48'sd26214;
      f2_tone_ff  <= f1_tone_ff;
      f3_bw_ff    <= 50'(eb_sh) * 50'sd39322;
      f3_tw_ff    <= f2_tw_ff;
      f3_tone_ff  <= f2_tone_ff;
      f4_v_ff     <= marker_ff ? mix_in : 35'(f3_tone_ff);
      f5_prod_ff  <= 53'(f4_v_ff) * 53'(amp_s);
      if (res_in > HI) begin
         rsp_sample_ff <= HI[SAMPLE_WIDTH-1:0];
      end else if (res_in < LO) begin
         rsp_sample_ff <= LO[SAMPLE_WIDTH-1:0];
      end else begin
         rsp_sample_ff <= res_in[SAMPLE_WIDTH-1:0];
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_sample_value = rsp_sample_ff;

   // side paths must line up with the tone path
   `TTMG_ASSERT_SAME(a_burst_align, clock, reset, t_valid || b_valid, t_valid && b_valid)
   `TTMG_ASSERT_SAME(a_env_align, clock, reset, t_valid || e_valid, t_valid && e_valid)
   `TTMG_ASSERT_SAME(a_frame_align, clock, reset, a_valid || a_valid_r, a_valid && a_valid_r)
   `TTMG_ASSERT_SAME(a_env_range, clock, reset, f1_valid_ff, f1_env_ff <= 17'd65536)
   `TTMG_ASSERT_NEXT(a_out_follows, clock, reset, f5_valid_ff, rsp_valid)

endmodule
